>>> rtl/core/lcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

    localparam int CountW = 16;
    localparam int LuxW   = 14;
    localparam int CoefW  = 16;
    localparam int ProdW  = 26;
    localparam int ApbAddrW = 3;

    // gain settings
    localparam logic [1:0] GainUnity = 2'd0;
    localparam logic [1:0] GainX8    = 2'd1;
    localparam logic [1:0] GainX16   = 2'd2;
    localparam logic [1:0] GainHigh  = 2'd3;

    // register index, taken from paddr[2]
    localparam logic RegGain = 1'b0;

    // q16 channel scales at the highest gain: 65536/107 and 65536/115
    localparam logic [9:0] HiScale0 = 10'd612;
    localparam logic [9:0] HiScale1 = 10'd569;

    // ratio <= limit  <=>  ch1 * 1024 < (2 * limit + 1) * ch0, for ch0 != 0
    // limits 0x9a, 0xc3, 0xe6, 0x114
    localparam logic [9:0] SegCmp0 = 10'd309;
    localparam logic [9:0] SegCmp1 = 10'd391;
    localparam logic [9:0] SegCmp2 = 10'd461;
    localparam logic [9:0] SegCmp3 = 10'd553;

    localparam logic [CountW-1:0] SatCount = 16'd4095;
    localparam logic [LuxW-1:0]   SatLux   = 14'd675;

    typedef logic [2:0] seg_t;

    typedef struct packed {
        logic [CountW-1:0] ch0;
        logic [CountW-1:0] ch1;
    } scaled_t;

    typedef struct packed {
        logic [CountW-1:0] ch0;
        logic [CountW-1:0] ch1;
        logic [CoefW-1:0]  b;
        logic [CoefW-1:0]  m;
        logic              sat;
    } coef_t;

    function automatic logic [CoefW-1:0] seg_b(input seg_t seg);
        logic [CoefW-1:0] r;
        case (seg)
            3'd0:    r = 16'h2148;
            3'd1:    r = 16'h2a37;
            3'd2:    r = 16'h18ef;
            3'd3:    r = 16'h0fdf;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic logic [CoefW-1:0] seg_m(input seg_t seg);
        logic [CoefW-1:0] r;
        case (seg)
            3'd0:    r = 16'h3d71;
            3'd1:    r = 16'h5b30;
            3'd2:    r = 16'h2db9;
            3'd3:    r = 16'h199a;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lcc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] broadband_count;
    logic [15:0] infrared_count;

    modport source (output valid, output broadband_count, output infrared_count, input ready);
    modport sink   (input valid, input broadband_count, input infrared_count, output ready);
endinterface

interface lcc_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] lux_value;

    modport source (output valid, output lux_value, input ready);
    modport sink   (input valid, input lux_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lcc_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module lcc_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcc_pkg::ApbAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [1:0]                    gain_code
);
    import lcc_pkg::*;

    logic [1:0] gain_reg;
    logic [1:0] gain_next;
    logic       wr_gain;

    assign pready  = 1'b1;
    assign wr_gain = psel && penable && pwrite && (paddr[2] == RegGain);

    always_comb
    begin
        gain_next = gain_reg;
        if (wr_gain)
        begin
            gain_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GainUnity;
        end
        else
        begin
            gain_reg <= gain_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == RegGain)
        begin
            prdata = {30'd0, gain_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign gain_code = gain_reg;

endmodule

`default_nettype wire

>>> rtl/core/lcc_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module lcc_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 gain_code,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  logic [lcc_pkg::CountW-1:0] broadband_count,
    input  logic [lcc_pkg::CountW-1:0] infrared_count,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output lcc_pkg::scaled_t           dn_data
);
    import lcc_pkg::*;

    logic           valid_reg;
    scaled_t        data_reg;
    scaled_t        data_next;
    logic [25:0]    hi0;
    logic [25:0]    hi1;

    // highest gain scale, q16 product
    assign hi0 = {10'd0, broadband_count} * {16'd0, HiScale0};
    assign hi1 = {10'd0, infrared_count} * {16'd0, HiScale1};

    always_comb
    begin
        case (gain_code)
            GainUnity:
            begin
                data_next.ch0 = broadband_count;
                data_next.ch1 = infrared_count;
            end
            GainX8:
            begin
                data_next.ch0 = {3'd0, broadband_count[15:3]};
                data_next.ch1 = {3'd0, infrared_count[15:3]};
            end
            GainX16:
            begin
                data_next.ch0 = {4'd0, broadband_count[15:4]};
                data_next.ch1 = {4'd0, infrared_count[15:4]};
            end
            default:
            begin
                data_next.ch0 = {6'd0, hi0[25:16]};
                data_next.ch1 = {6'd0, hi1[25:16]};
            end
        endcase
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/core/lcc_segment.sv
`timescale 1ns / 1ps
`default_nettype none

module lcc_segment (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  lcc_pkg::scaled_t up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output lcc_pkg::coef_t   dn_data
);
    import lcc_pkg::*;

    // stage 2: ratio compare products
    logic              s2_valid_reg;
    logic [CountW-1:0] s2_ch0_reg;
    logic [CountW-1:0] s2_ch1_reg;
    logic [ProdW-1:0]  s2_prod_reg [4];
    logic [ProdW-1:0]  s2_prod_next [4];
    logic              s2_ready;

    // stage 3: segment pick and coefficients
    logic              s3_valid_reg;
    coef_t             s3_data_reg;
    coef_t             s3_data_next;
    logic              s3_ready;
    logic [ProdW-1:0]  ch1_x1024;
    seg_t              seg;

    assign s2_prod_next[0] = {10'd0, up_data.ch0} * {16'd0, SegCmp0};
    assign s2_prod_next[1] = {10'd0, up_data.ch0} * {16'd0, SegCmp1};
    assign s2_prod_next[2] = {10'd0, up_data.ch0} * {16'd0, SegCmp2};
    assign s2_prod_next[3] = {10'd0, up_data.ch0} * {16'd0, SegCmp3};

    assign s3_ready = !s3_valid_reg || dn_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign up_ready = s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= up_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && up_valid)
        begin
            s2_ch0_reg <= up_data.ch0;
            s2_ch1_reg <= up_data.ch1;
            for (int k = 0; k < 4; k++)
            begin
                s2_prod_reg[k] <= s2_prod_next[k];
            end
        end
    end

    assign ch1_x1024 = {s2_ch1_reg, 10'd0};

    // first segment whose limit holds; zero broadband means ratio zero
    always_comb
    begin
        seg = 3'd4;
        for (int k = 3; k >= 0; k--)
        begin
            if (ch1_x1024 < s2_prod_reg[k])
            begin
                seg = 3'(k);
            end
        end
        if (s2_ch0_reg == '0)
        begin
            seg = 3'd0;
        end
    end

    always_comb
    begin
        s3_data_next.ch0 = s2_ch0_reg;
        s3_data_next.ch1 = s2_ch1_reg;
        s3_data_next.b   = seg_b(seg);
        s3_data_next.m   = seg_m(seg);
        s3_data_next.sat = (s2_ch0_reg == SatCount) && (s2_ch1_reg == SatCount);
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_data_reg <= s3_data_next;
        end
    end

    assign dn_valid = s3_valid_reg;
    assign dn_data  = s3_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/lcc_lux.sv
`timescale 1ns / 1ps
`default_nettype none

module lcc_lux (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  lcc_pkg::coef_t           up_data,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output logic [lcc_pkg::LuxW-1:0] lux_value
);
    import lcc_pkg::*;

    // stage 4: the two products
    logic          s4_valid_reg;
    logic [31:0]   s4_pos_reg;
    logic [31:0]   s4_neg_reg;
    logic          s4_sat_reg;
    logic          s4_ready;

    // stage 5: clamp, round, output word
    logic            s5_valid_reg;
    logic [LuxW-1:0] s5_lux_reg;
    logic [LuxW-1:0] s5_lux_next;
    logic            s5_ready;
    logic [31:0]     diff;
    logic [32:0]     rounded;

    assign s5_ready = !s5_valid_reg || dn_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign up_ready = s4_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= up_valid;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && up_valid)
        begin
            s4_pos_reg <= {16'd0, up_data.ch0} * {16'd0, up_data.b};
            s4_neg_reg <= {16'd0, up_data.ch1} * {16'd0, up_data.m};
            s4_sat_reg <= up_data.sat;
        end
    end

    // negative difference clamps to zero
    assign diff    = (s4_pos_reg > s4_neg_reg) ? (s4_pos_reg - s4_neg_reg) : 32'd0;
    assign rounded = {1'b0, diff} + 33'd32768;

    always_comb
    begin
        if (s4_sat_reg)
        begin
            s5_lux_next = SatLux;
        end
        else
        begin
            s5_lux_next = rounded[29:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && s4_valid_reg)
        begin
            s5_lux_reg <= s5_lux_next;
        end
    end

    assign dn_valid  = s5_valid_reg;
    assign lux_value = s5_lux_reg;

endmodule

`default_nettype wire

>>> rtl/core/two_channel_lux_calc_core.sv
// channel     dir   handshake      payload
// sample_in   in    valid/ready    broadband_count[15:0], infrared_count[15:0]
// lux_out     out   valid/ready    lux_value[13:0]
// apb         in    psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// five register stages: scale, ratio products, segment pick, products, round
// one word enters per cycle unless lux_out stalls with every stage full
// each stage holds its own valid bit and takes a word when empty or draining,
// so bubbles fill up while the output word waits
// rst_n clears the valid bits and the gain register asynchronously
`timescale 1ns / 1ps
`default_nettype none

module two_channel_lux_calc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    lcc_in_if.sink                        sample_in,
    lcc_out_if.source                     lux_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcc_pkg::ApbAddrW-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lcc_pkg::*;

    logic       [1:0] gain_code;

    // scale -> segment
    logic             sc_valid;
    logic             sc_ready;
    scaled_t          sc_data;

    // segment -> lux
    logic             sg_valid;
    logic             sg_ready;
    coef_t            sg_data;

    // gain register; write it only while the pipeline is empty (the block does not enforce this)
    lcc_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .gain_code (gain_code)
    );

    // stage 1: gain normalization of both counts
    lcc_scale u_scale (
        .clk             (clk),
        .rst_n           (rst_n),
        .gain_code       (gain_code),
        .up_valid        (sample_in.valid),
        .up_ready        (sample_in.ready),
        .broadband_count (sample_in.broadband_count),
        .infrared_count  (sample_in.infrared_count),
        .dn_valid        (sc_valid),
        .dn_ready        (sc_ready),
        .dn_data         (sc_data)
    );

    // stages 2 and 3: ratio threshold compares replace the divide,
    // then the segment coefficients are looked up
    lcc_segment u_segment (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sc_valid),
        .up_ready (sc_ready),
        .up_data  (sc_data),
        .dn_valid (sg_valid),
        .dn_ready (sg_ready),
        .dn_data  (sg_data)
    );

    // stages 4 and 5: ch0*b and ch1*m, then clamp, round and saturation
    lcc_lux u_lux (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (sg_valid),
        .up_ready  (sg_ready),
        .up_data   (sg_data),
        .dn_valid  (lux_out.valid),
        .dn_ready  (lux_out.ready),
        .lux_value (lux_out.lux_value)
    );

endmodule

`default_nettype wire

>>> rtl/core/lcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [13:0] lux_value,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import lcc_pkg::*;

    logic wr_gain;
    assign wr_gain = psel && penable && pwrite && (paddr[2] == RegGain);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lux_value))
        else $error("output word changed while stalled");

    // an empty output stage means every stage can take a word
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // lux never exceeds the top of the range
    a_lux_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lux_value <= 14'd10807)
        else $error("lux out of range");

    // gain readback follows the last write
    a_gain_readback: assert property (@(posedge clk) disable iff (!rst_n)
        wr_gain ##1 (paddr[2] == RegGain) |-> prdata == {30'd0, $past(pwdata[1:0])})
        else $error("gain readback mismatch");

endmodule

bind two_channel_lux_calc_core lcc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample_in.ready),
    .out_valid (lux_out.valid),
    .out_ready (lux_out.ready),
    .lux_value (lux_out.lux_value),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire
